[sv/brcc_pkg.sv]
`timescale 1ns / 1ps

package brcc_pkg;

	// record layout
	localparam logic [2:0]  POS_FIRST   = 3'd0;
	localparam logic [2:0]  POS_SIZE_LS = 3'd3;
	localparam logic [2:0]  POS_STATE   = 3'd4;
	localparam logic [2:0]  POS_CRC_HI  = 3'd5;
	localparam logic [2:0]  POS_LAST    = 3'd6;

	// crc-16, reflected, modbus style
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	// state byte value that means an upgrade is waiting
	localparam logic [7:0]  STATE_UPGRADE = 8'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} brcc_in_t;

	typedef struct packed {
		logic        record_valid;
		logic [31:0] image_size;
		logic [7:0]  image_state;
		logic        upgrade_pending;
	} brcc_out_t;

	// one byte through the reflected crc, lsb first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[sv/brcc_result_reg.sv]
`timescale 1ns / 1ps

module brcc_result_reg
	import brcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  brcc_out_t load_data,
	output logic      can_take,
	output logic      result_valid,
	input  logic      result_ready,
	output brcc_out_t result_data
);

	logic      valid_q;
	brcc_out_t data_q;

	// free when empty or being emptied this cycle
	assign can_take = !valid_q || result_ready;

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !result_ready);
		end
	end

	// result payload, held while stalled
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign result_valid = valid_q;
	assign result_data  = data_q;

endmodule

[sv/boot_record_crc_checker_core.sv]
// order: a byte is taken into the input register, then processed into the
//   record state; the result of byte 6 is loaded into the result register
// rate: one byte per cycle unless stalled, one result per seven-byte record
// a full result register that is not taken stalls the input register
// reset: asynchronous, active low; position clears, crc loads 0xffff,
//   size, state and stored crc byte clear, no item or result held
`timescale 1ns / 1ps

module boot_record_crc_checker_core
	import brcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_ready,
	input  brcc_in_t  byte_data,
	output logic      result_valid,
	input  logic      result_ready,
	output brcc_out_t result_data
);

	logic        valid_s1;
	brcc_in_t    data_s1;
	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic [31:0] size_q;
	logic [7:0]  state_q;
	logic [7:0]  crc_hi_q;

	logic        can_take;
	logic        fire_s1;
	logic [2:0]  pos;
	logic [15:0] crc_base;
	logic [31:0] size_base;
	logic        rec_ok;
	logic        res_load;
	brcc_out_t   res_data;

	// input register moves on when empty or when its item is processed
	assign fire_s1    = valid_s1 && can_take;
	assign byte_ready = !valid_s1 || can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= byte_data;
		end
	end

	// position of this item, restart on first-byte flag or stray code
	always_comb begin
		if (data_s1.first_byte || pos_q > POS_LAST) begin
			pos = POS_FIRST;
		end else begin
			pos = pos_q;
		end
	end

	assign crc_base  = (pos == POS_FIRST) ? CRC_INIT : crc_q;
	assign size_base = (pos == POS_FIRST) ? 32'd0 : size_q;

	// crc check on the last byte
	assign rec_ok = (crc_hi_q == crc_q[15:8]) && (data_s1.data_byte == crc_q[7:0]);

	always_comb begin
		res_data.record_valid    = rec_ok;
		res_data.image_size      = rec_ok ? size_q : 32'd0;
		res_data.image_state     = rec_ok ? state_q : 8'd0;
		res_data.upgrade_pending = rec_ok && (state_q == STATE_UPGRADE);
	end

	assign res_load = fire_s1 && (pos == POS_LAST);

	// record state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			crc_q    <= CRC_INIT;
			size_q   <= 32'd0;
			state_q  <= 8'd0;
			crc_hi_q <= 8'd0;
		end else if (fire_s1) begin
			if (pos < POS_CRC_HI) begin
				crc_q <= crc16_byte(crc_base, data_s1.data_byte);
			end else begin
				crc_q <= crc_base;
			end
			if (pos <= POS_SIZE_LS) begin
				size_q <= {size_base[23:0], data_s1.data_byte};
			end else begin
				size_q <= size_base;
			end
			if (pos == POS_STATE) begin
				state_q <= data_s1.data_byte;
			end
			if (pos == POS_CRC_HI) begin
				crc_hi_q <= data_s1.data_byte;
			end
			if (pos == POS_LAST) begin
				pos_q <= POS_FIRST;
			end else begin
				pos_q <= pos + 3'd1;
			end
		end
	end

	brcc_result_reg u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (res_load),
		.load_data    (res_data),
		.can_take     (can_take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

[sv/brcc_checker.sv]
`timescale 1ns / 1ps

module brcc_checker
	import brcc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      byte_valid,
	input logic      byte_ready,
	input logic      result_valid,
	input logic      result_ready,
	input brcc_out_t result_data
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// an invalid record shows no size or state
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.record_valid |->
			result_data.image_size == 32'd0 && result_data.image_state == 8'd0)
		else $error("invalid record leaks size or state");

	// pending flag only on a valid record in upgrade state
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.upgrade_pending ==
			(result_data.record_valid && result_data.image_state == STATE_UPGRADE))
		else $error("upgrade flag wrong");

	// a fresh result follows an item taken into the input register and processed there
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(byte_valid && byte_ready, 2))
		else $error("result without an item");

endmodule

bind boot_record_crc_checker_core brcc_checker u_brcc_checker (.*);
